@@ sv/context_count_forced_byte_coder_top_macros.svh @@
// Assertion macros for the context coder top level.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef CONTEXT_COUNT_FORCED_BYTE_CODER_TOP_MACROS_SVH
`define CONTEXT_COUNT_FORCED_BYTE_CODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCFBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, disabled during reset.
`define CCFBC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ sv/ccfbc_pkg.sv @@
// Shared types, codes and helpers for the context coder.
// Used by the hash unit, the table store and the top level.
package ccfbc_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] OP_SEED   = 3'd0;
    localparam logic [2:0] OP_COUNT  = 3'd1;
    localparam logic [2:0] OP_ENCODE = 3'd2;
    localparam logic [2:0] OP_DECODE = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_DEAD     = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_ZERO     = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_byte;
        logic [63:0] entry_key;
        logic [31:0] entry_count;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic       forced;
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       key_consumed;
    } out_word_t;

    typedef struct packed {
        logic        we;
        logic [63:0] key;
        logic [31:0] count;
    } ent_wr_t;

    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [31:0] count;
    } ent_rd_t;

    typedef struct packed {
        logic        we;
        logic [55:0] key;
        logic [8:0]  live;
        logic [7:0]  sole;
    } ctx_wr_t;

    typedef struct packed {
        logic        used;
        logic [55:0] key;
        logic [8:0]  live;
        logic [7:0]  sole;
    } ctx_rd_t;

    // Shift a byte into the context window and keep 8*order bits.
    function automatic logic [55:0] shift_window(logic [55:0] ctx, logic [7:0] b,
                                                 logic [2:0] order);
        logic [55:0] mask;
        logic [55:0] nxt;
        nxt = {ctx[47:0], b};
        if (order == 3'd0)
            mask = '0;
        else if (order == 3'd7)
            mask = '1;
        else
            mask = (56'd1 << {order, 3'b000}) - 56'd1;
        return nxt & mask;
    endfunction

endpackage

@@ sv/ccfbc_hash.sv @@
// Iterative multiplicative hash: one 16-bit key slice per cycle, over all four slices of the key.
// Depends on ccfbc_pkg for the hash multiplier.
module ccfbc_hash #(
    parameter int TABLE_ENTRIES = ccfbc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [63:0]                      key,
    output logic                             done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] home
);
    import ccfbc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic [63:0] key_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] prod;
    logic [1:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    always_comb
    begin
        prod = 64'(key_reg[{cnt_reg, 4'b0000} +: 16]) * HASH_MUL;
        acc_next = acc_reg + (prod << {cnt_reg, 4'b0000});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
            acc_reg <= '0;
        end
        else if (run_reg)
            acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign home = acc_reg[32 +: IW];

endmodule

@@ sv/ccfbc_store.sv @@
// Transition and context tables with registered reads and a clearing sweep.
// Depends on ccfbc_pkg for the read and write word types.
module ccfbc_store #(
    parameter int TABLE_ENTRIES = ccfbc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] e_waddr,
    input  ccfbc_pkg::ent_wr_t               e_wr,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] c_waddr,
    input  ccfbc_pkg::ctx_wr_t               c_wr,
    output ccfbc_pkg::ent_rd_t               e_rd,
    output ccfbc_pkg::ctx_rd_t               c_rd,
    output logic                             clearing
);
    import ccfbc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    logic        e_used_mem  [TABLE_ENTRIES];
    logic [63:0] e_key_mem   [TABLE_ENTRIES];
    logic [31:0] e_count_mem [TABLE_ENTRIES];
    logic        c_used_mem  [TABLE_ENTRIES];
    logic [55:0] c_key_mem   [TABLE_ENTRIES];
    logic [8:0]  c_live_mem  [TABLE_ENTRIES];
    logic [7:0]  c_sole_mem  [TABLE_ENTRIES];

    logic [IW-1:0] clr_reg;
    logic          clearing_reg;

    // Sweep the used bits once after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == IW'(TABLE_ENTRIES - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            e_used_mem[clr_reg] <= 1'b0;
        else if (e_wr.we)
            e_used_mem[e_waddr] <= 1'b1;
        if (e_wr.we)
        begin
            e_key_mem[e_waddr]   <= e_wr.key;
            e_count_mem[e_waddr] <= e_wr.count;
        end
        e_rd <= '{used: e_used_mem[raddr], key: e_key_mem[raddr],
                  count: e_count_mem[raddr]};
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            c_used_mem[clr_reg] <= 1'b0;
        else if (c_wr.we)
            c_used_mem[c_waddr] <= 1'b1;
        if (c_wr.we)
        begin
            c_key_mem[c_waddr]  <= c_wr.key;
            c_live_mem[c_waddr] <= c_wr.live;
            c_sole_mem[c_waddr] <= c_wr.sole;
        end
        c_rd <= '{used: c_used_mem[raddr], key: c_key_mem[raddr],
                  live: c_live_mem[raddr], sole: c_sole_mem[raddr]};
    end

    assign clearing = clearing_reg;

endmodule

@@ sv/context_count_forced_byte_coder_top.sv @@
// Order-k byte context coder: seed, count, load, encode and decode commands
// over a hashed transition table. One command at a time; busy is high while
// a command runs and after reset while the table's used bits are swept
// clear. Each table lookup runs the hash and then a linear probe, with one
// read and one check per probe step. Count and load do two lookups, as do
// encode and decode. When a take leaves one live successor, a scan of up to
// 256 further lookups finds it. The tables share one read address and all
// lookups share one hash unit, so commands are handled one at a time.
// Each result shows on result with done high for one cycle, with no stall.
// Depends on ccfbc_pkg, ccfbc_hash, ccfbc_store and the macros header.
`include "context_count_forced_byte_coder_top_macros.svh"

module context_count_forced_byte_coder_top #(
    parameter int TABLE_ENTRIES = ccfbc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ccfbc_pkg::in_word_t  cmd,
    output logic                 done,
    output ccfbc_pkg::out_word_t result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import ccfbc_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_HASH  = 7'b000_0010,
        S_RD    = 7'b000_0100,
        S_CHK   = 7'b000_1000,
        S_PUTWR = 7'b001_0000,
        S_TKWR  = 7'b010_0000,
        S_DONE  = 7'b100_0000
    } state_t;

    localparam logic [2:0] PH_PUT_E = 3'd0;
    localparam logic [2:0] PH_PUT_C = 3'd1;
    localparam logic [2:0] PH_TK_C  = 3'd2;
    localparam logic [2:0] PH_TK_E  = 3'd3;
    localparam logic [2:0] PH_SCAN  = 3'd4;

    state_t        state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    order_reg;
    logic [55:0]   window_reg, window_next;
    logic [2:0]    op_reg, op_next;
    logic [7:0]    db_reg, db_next;
    logic [31:0]   ecount_reg, ecount_next;
    logic [55:0]   ctx_reg, ctx_next;
    logic [7:0]    sym_reg, sym_next;
    logic [63:0]   key_reg, key_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] step_reg, step_next;
    logic [IW-1:0] e_reg, e_next;
    logic [IW-1:0] c_reg, c_next;
    logic [31:0]   old_reg, old_next;
    logic [31:0]   nv_reg, nv_next;
    logic [8:0]    live_reg, live_next;
    logic [7:0]    sole_reg, sole_next;
    logic          one_reg, one_next;
    logic [7:0]    x_reg, x_next;
    out_word_t     res_reg, res_next;

    logic          probe_go;
    logic [63:0]   probe_key;
    logic          hash_done;
    logic [IW-1:0] hash_home;
    ent_wr_t       e_wr;
    ctx_wr_t       c_wr;
    ent_rd_t       e_rd;
    ctx_rd_t       c_rd;
    logic          clearing;
    logic          is_ctx, used, keyeq, hit, advance, fin, inc;
    logic          one_c;
    logic [7:0]    sym_c;
    logic          bvalid_c;

    ccfbc_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (probe_go),
        .key   (probe_key),
        .done  (hash_done),
        .home  (hash_home)
    );

    ccfbc_store #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .raddr    (idx_reg),
        .e_waddr  (e_reg),
        .e_wr     (e_wr),
        .c_waddr  (c_reg),
        .c_wr     (c_wr),
        .e_rd     (e_rd),
        .c_rd     (c_rd),
        .clearing (clearing)
    );

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= 3'd1;
        else if (psel && penable && pwrite && !paddr[2])
            order_reg <= pwdata[2:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {29'd0, order_reg};

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        window_next = window_reg;
        op_next     = op_reg;
        db_next     = db_reg;
        ecount_next = ecount_reg;
        ctx_next    = ctx_reg;
        sym_next    = sym_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        step_next   = step_reg;
        e_next      = e_reg;
        c_next      = c_reg;
        old_next    = old_reg;
        nv_next     = nv_reg;
        live_next   = live_reg;
        sole_next   = sole_reg;
        one_next    = one_reg;
        x_next      = x_reg;
        res_next    = res_reg;
        probe_go    = 1'b0;
        probe_key   = '0;
        e_wr        = '0;
        c_wr        = '0;
        fin         = 1'b0;
        one_c       = 1'b0;
        sym_c       = '0;
        inc         = 1'b0;

        is_ctx  = (phase_reg == PH_PUT_C) || (phase_reg == PH_TK_C);
        used    = is_ctx ? c_rd.used : e_rd.used;
        keyeq   = is_ctx ? (c_rd.key == key_reg[55:0]) : (e_rd.key == key_reg);
        hit     = used && keyeq;
        advance = used && !keyeq && (step_reg != IW'(TABLE_ENTRIES - 1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (start && !clearing)
                begin
                    op_next     = cmd.opcode;
                    db_next     = cmd.data_byte;
                    ecount_next = cmd.entry_count;
                    res_next    = '0;
                    ctx_next    = window_reg;
                    sym_next    = cmd.data_byte;
                    state_next  = S_DONE;
                    unique case (cmd.opcode) inside
                        OP_SEED:
                            window_next = shift_window(window_reg, cmd.data_byte, order_reg);
                        OP_COUNT:
                        begin
                            probe_go   = 1'b1;
                            probe_key  = {window_reg, cmd.data_byte};
                            phase_next = PH_PUT_E;
                        end
                        OP_LOAD:
                        begin
                            if (cmd.entry_count == 32'd0)
                                res_next.status = ST_ZERO;
                            else
                            begin
                                ctx_next   = cmd.entry_key[63:8];
                                sym_next   = cmd.entry_key[7:0];
                                probe_go   = 1'b1;
                                probe_key  = cmd.entry_key;
                                phase_next = PH_PUT_E;
                            end
                        end
                        OP_ENCODE, OP_DECODE:
                        begin
                            probe_go   = 1'b1;
                            probe_key  = {8'd0, window_reg};
                            phase_next = PH_TK_C;
                        end
                        default: ;
                    endcase
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    idx_next   = hash_home;
                    step_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (advance)
                begin
                    idx_next   = idx_reg + 1'b1;
                    step_next  = step_reg + 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_DONE;
                    case (phase_reg)
                        PH_PUT_E:
                        begin
                            if (used && !hit)
                                res_next.status = ST_FULL;
                            else
                            begin
                                e_next     = idx_reg;
                                old_next   = hit ? e_rd.count : 32'd0;
                                probe_go   = 1'b1;
                                probe_key  = {8'd0, ctx_reg};
                                phase_next = PH_PUT_C;
                            end
                        end
                        PH_PUT_C:
                        begin
                            if (used && !hit)
                                res_next.status = ST_FULL;
                            else if (op_reg != OP_LOAD && old_reg == COUNT_MAX)
                                res_next.status = ST_OVERFLOW;
                            else
                            begin
                                c_next     = idx_reg;
                                live_next  = hit ? c_rd.live : 9'd0;
                                sole_next  = c_rd.sole;
                                nv_next    = (op_reg == OP_LOAD) ? ecount_reg
                                                                 : old_reg + 32'd1;
                                state_next = S_PUTWR;
                            end
                        end
                        PH_TK_C:
                        begin
                            one_c = (c_rd.live == 9'd1);
                            sym_c = (op_reg == OP_DECODE && one_c) ? c_rd.sole : db_reg;
                            if (!hit || c_rd.live == 9'd0)
                                res_next.status = ST_DEAD;
                            else if (op_reg == OP_ENCODE && one_c && c_rd.sole != db_reg)
                                res_next.status = ST_MISMATCH;
                            else
                            begin
                                c_next     = idx_reg;
                                live_next  = c_rd.live;
                                sole_next  = c_rd.sole;
                                one_next   = one_c;
                                sym_next   = sym_c;
                                probe_go   = 1'b1;
                                probe_key  = {ctx_reg, sym_c};
                                phase_next = PH_TK_E;
                            end
                        end
                        PH_TK_E:
                        begin
                            if (!hit || e_rd.count == 32'd0)
                                res_next.status = ST_INVALID;
                            else
                            begin
                                e_next     = idx_reg;
                                nv_next    = e_rd.count - 32'd1;
                                state_next = S_TKWR;
                            end
                        end
                        PH_SCAN:
                        begin
                            if (hit && e_rd.count != 32'd0)
                            begin
                                c_wr = '{we: 1'b1, key: ctx_reg, live: 9'd1, sole: x_reg};
                                fin  = 1'b1;
                            end
                            else if (x_reg == 8'hFF)
                                fin = 1'b1;
                            else
                            begin
                                x_next    = x_reg + 8'd1;
                                probe_go  = 1'b1;
                                probe_key = {ctx_reg, x_reg + 8'd1};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PUTWR:
            begin
                inc  = (old_reg == 32'd0) && (nv_reg != 32'd0);
                e_wr = '{we: 1'b1, key: {ctx_reg, sym_reg}, count: nv_reg};
                c_wr = '{we: 1'b1, key: ctx_reg,
                         live: inc ? live_reg + 9'd1 : live_reg,
                         sole: (inc && live_reg == 9'd0) ? sym_reg : sole_reg};
                if (op_reg == OP_COUNT)
                    window_next = shift_window(ctx_reg, sym_reg, order_reg);
                state_next = S_DONE;
            end
            S_TKWR:
            begin
                e_wr = '{we: 1'b1, key: {ctx_reg, sym_reg}, count: nv_reg};
                fin  = 1'b1;
                if (nv_reg == 32'd0 && live_reg != 9'd0)
                begin
                    c_wr = '{we: 1'b1, key: ctx_reg, live: live_reg - 9'd1, sole: sole_reg};
                    // One live successor left: scan for it.
                    if (live_reg == 9'd2)
                    begin
                        fin        = 1'b0;
                        x_next     = 8'd0;
                        probe_go   = 1'b1;
                        probe_key  = {ctx_reg, 8'd0};
                        phase_next = PH_SCAN;
                    end
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase

        if (probe_go)
        begin
            key_next   = probe_key;
            state_next = S_HASH;
        end

        bvalid_c = (op_reg == OP_DECODE) || !one_reg;
        if (fin)
        begin
            res_next.status       = ST_OK;
            res_next.forced       = one_reg;
            res_next.byte_valid   = bvalid_c;
            res_next.out_byte     = bvalid_c ? sym_reg : 8'd0;
            res_next.key_consumed = (op_reg == OP_DECODE) && !one_reg;
            window_next           = shift_window(ctx_reg, sym_reg, order_reg);
            state_next            = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_PUT_E;
            window_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        db_reg     <= db_next;
        ecount_reg <= ecount_next;
        ctx_reg    <= ctx_next;
        sym_reg    <= sym_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        e_reg      <= e_next;
        c_reg      <= c_next;
        old_reg    <= old_next;
        nv_reg     <= nv_next;
        live_reg   <= live_next;
        sole_reg   <= sole_next;
        one_reg    <= one_next;
        x_reg      <= x_next;
        res_reg    <= res_next;
    end

    assign busy   = (state_reg != S_IDLE) || clearing;
    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

    `CCFBC_ASSERT_IMP(a_done_busy, done, busy)
    `CCFBC_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `CCFBC_ASSERT_NXT(a_done_pulse, done, !done)
    `CCFBC_ASSERT_IMP(a_err_clean, done && result.status != ST_OK,
                      !result.forced && !result.byte_valid && !result.key_consumed)

endmodule
